[src/bcy_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcy_pkg: shared types and codes for the Bezier y-at-x solver
// Transaction payload structs, controller/datapath command and status
// structs, multiplier and writeback operation codes.
// ----------------------------------------------------------------------------
package bcy_pkg;

  localparam int DATA_W             = 32;
  localparam int TOL_W              = 16;
  localparam int DEF_T_FRAC_BITS    = 16;
  localparam int DEF_MAX_ITERATIONS = 16;

  localparam logic [TOL_W-1:0] XTOL_RESET = 16'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_target;
    logic signed [DATA_W-1:0] start_x;
    logic signed [DATA_W-1:0] start_y;
    logic signed [DATA_W-1:0] handle_a_x;
    logic signed [DATA_W-1:0] handle_a_y;
    logic signed [DATA_W-1:0] handle_b_x;
    logic signed [DATA_W-1:0] handle_b_y;
    logic signed [DATA_W-1:0] end_x;
    logic signed [DATA_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_value;
    logic                     converged;
  } out_item_t;

  // multiplier operand pair
  typedef logic [3:0] mul_op_t;
  localparam mul_op_t MUL_NONE = 4'd0;
  localparam mul_op_t MUL_TT   = 4'd1;
  localparam mul_op_t MUL_SS   = 4'd2;
  localparam mul_op_t MUL_T2T  = 4'd3;
  localparam mul_op_t MUL_S2S  = 4'd4;
  localparam mul_op_t MUL_S2T  = 4'd5;
  localparam mul_op_t MUL_ST2  = 4'd6;
  localparam mul_op_t MUL_W0P  = 4'd7;
  localparam mul_op_t MUL_W1P  = 4'd8;
  localparam mul_op_t MUL_W2P  = 4'd9;
  localparam mul_op_t MUL_W3P  = 4'd10;

  // destination of the registered product
  typedef logic [3:0] wb_op_t;
  localparam wb_op_t WB_NONE    = 4'd0;
  localparam wb_op_t WB_T2      = 4'd1;
  localparam wb_op_t WB_S2      = 4'd2;
  localparam wb_op_t WB_W3      = 4'd3;
  localparam wb_op_t WB_W0      = 4'd4;
  localparam wb_op_t WB_W1      = 4'd5;
  localparam wb_op_t WB_W2      = 4'd6;
  localparam wb_op_t WB_ACC_LD  = 4'd7;
  localparam wb_op_t WB_ACC_ADD = 4'd8;
  localparam wb_op_t WB_XR      = 4'd9;

  typedef struct packed {
    logic    load;      // latch input, reset bounds, t = 0.5
    logic    calc_s;    // s = 1 - t
    mul_op_t mul_op;
    logic    sel_y;     // product uses y control points
    wb_op_t  wb_op;
    logic    step_t;    // move a bound, t = midpoint
    logic    set_conv;  // latch tolerance test
    logic    finish;    // load output register
  } bcy_cmd_t;

  typedef struct packed {
    logic in_tol;    // |x_target - x(t)| <= tolerance
    logic xt_gt;     // x_target > x(t)
    logic t_at_one;
  } bcy_status_t;

endpackage
`default_nettype wire

[src/bcy_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcy_datapath: shared multiplier, weight registers, accumulator
// Evaluates the cubic Bernstein polynomial one product per cycle under
// controller command, and holds bisection bounds and the output register.
// ----------------------------------------------------------------------------
module bcy_datapath import bcy_pkg::*; #(
  parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [TOL_W-1:0]  cfg_wr_data,
  input  wire in_item_t          in_data,
  input  wire bcy_cmd_t          cmd,
  output bcy_status_t            status,
  output out_item_t              out_data
);

  localparam int TW  = T_FRAC_BITS + 1;   // t in [0,1]
  localparam int MW  = TW + 1;            // signed view of the unsigned operand
  localparam int BW  = DATA_W + 1;
  localparam int PW  = MW + BW;
  localparam int ACW = PW + 2;
  localparam int SW  = ACW - T_FRAC_BITS;

  localparam logic [TW-1:0] T_ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [TW-1:0] T_HALF = {2'b01, {(T_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] SAT_MAX =
    {{(SW-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN =
    {{(SW-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};

  in_item_t                 item;
  logic [TOL_W-1:0]         x_tolerance;
  logic [TW-1:0]            lower, upper, t, s, t2, s2;
  logic [TW-1:0]            w0, w1, w2, w3;
  logic signed [PW-1:0]     prod;
  logic signed [ACW-1:0]    acc;
  logic signed [DATA_W-1:0] xr;
  logic                     conv;

  logic [TW-1:0]            mul_a;
  logic signed [BW-1:0]     mul_b;
  logic signed [DATA_W-1:0] p0, p1, p2, p3;
  logic [PW+1:0]            prod3;
  logic [TW-1:0]            wt, wt3;
  logic signed [SW-1:0]     acc_sh;
  logic signed [DATA_W-1:0] val_sat;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          abs_diff;
  logic [TW-1:0]            lo_n, up_n;
  logic [TW:0]              mid_sum;

  assign p0 = cmd.sel_y ? item.start_y    : item.start_x;
  assign p1 = cmd.sel_y ? item.handle_a_y : item.handle_a_x;
  assign p2 = cmd.sel_y ? item.handle_b_y : item.handle_b_x;
  assign p3 = cmd.sel_y ? item.end_y      : item.end_x;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_TT:  begin mul_a = t;  mul_b = {{(BW-TW){1'b0}}, t};  end
      MUL_SS:  begin mul_a = s;  mul_b = {{(BW-TW){1'b0}}, s};  end
      MUL_T2T: begin mul_a = t2; mul_b = {{(BW-TW){1'b0}}, t};  end
      MUL_S2S: begin mul_a = s2; mul_b = {{(BW-TW){1'b0}}, s};  end
      MUL_S2T: begin mul_a = s2; mul_b = {{(BW-TW){1'b0}}, t};  end
      MUL_ST2: begin mul_a = s;  mul_b = {{(BW-TW){1'b0}}, t2}; end
      MUL_W0P: begin mul_a = w0; mul_b = {p0[DATA_W-1], p0};    end
      MUL_W1P: begin mul_a = w1; mul_b = {p1[DATA_W-1], p1};    end
      MUL_W2P: begin mul_a = w2; mul_b = {p2[DATA_W-1], p2};    end
      MUL_W3P: begin mul_a = w3; mul_b = {p3[DATA_W-1], p3};    end
      default: begin mul_a = '0; mul_b = '0;                    end
    endcase
  end

  // weight products are non-negative; truncation matches the floor shift
  assign prod3 = {2'b00, prod} + {1'b0, prod, 1'b0};
  assign wt    = prod[T_FRAC_BITS +: TW];
  assign wt3   = prod3[T_FRAC_BITS +: TW];

  // floor shift of the accumulator, then clamp to Q16.16
  assign acc_sh = acc[ACW-1:T_FRAC_BITS];
  always_comb begin
    if (acc_sh > SAT_MAX) begin
      val_sat = SAT_MAX[DATA_W-1:0];
    end else if (acc_sh < SAT_MIN) begin
      val_sat = SAT_MIN[DATA_W-1:0];
    end else begin
      val_sat = acc_sh[DATA_W-1:0];
    end
  end

  assign diff     = $signed({item.x_target[DATA_W-1], item.x_target})
                  - $signed({xr[DATA_W-1], xr});
  assign abs_diff = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;

  assign status.in_tol   = abs_diff <= {{(DATA_W+1-TOL_W){1'b0}}, x_tolerance};
  assign status.xt_gt    = !diff[DATA_W] && (diff != '0);
  assign status.t_at_one = (t == T_ONE);

  assign lo_n    = status.xt_gt ? t : lower;
  assign up_n    = status.xt_gt ? upper : t;
  assign mid_sum = {1'b0, lo_n} + {1'b0, up_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      x_tolerance <= XTOL_RESET;
    end else if (cfg_wr_en) begin
      x_tolerance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, mul_a}) * mul_b;

    if (cmd.load) begin
      item  <= in_data;
      lower <= '0;
      upper <= T_ONE;
      t     <= T_HALF;
    end
    if (cmd.step_t) begin
      lower <= lo_n;
      upper <= up_n;
      t     <= mid_sum[TW:1];
    end
    if (cmd.calc_s) begin
      s <= T_ONE - t;
    end

    case (cmd.wb_op)
      WB_T2:      t2  <= wt;
      WB_S2:      s2  <= wt;
      WB_W3:      w3  <= wt;
      WB_W0:      w0  <= wt;
      WB_W1:      w1  <= wt3;
      WB_W2:      w2  <= wt3;
      WB_ACC_LD:  acc <= ACW'(prod);
      WB_ACC_ADD: acc <= acc + ACW'(prod);
      WB_XR:      xr  <= val_sat;
      default: begin
      end
    endcase

    if (cmd.set_conv) begin
      conv <= status.in_tol;
    end
    if (cmd.finish) begin
      out_data.y_value   <= val_sat;
      out_data.converged <= conv;
    end
  end

endmodule
`default_nettype wire

[src/bcy_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcy_ctrl: sequencer for the bisection solver
// Steps the product schedule of one curve evaluation, decides each
// bisection round and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bcy_ctrl import bcy_pkg::*; #(
  parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire bcy_status_t status,
  output bcy_cmd_t         cmd
);

  localparam int RW = $clog2(MAX_ITERATIONS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_XEVAL = 2'd1;
  localparam logic [1:0] ST_YEVAL = 2'd2;

  // schedule positions
  localparam logic [3:0] STEP_FIRST   = 4'd0;
  localparam logic [3:0] STEP_Y_FIRST = 4'd6;   // first weight * point product
  localparam logic [3:0] STEP_RES     = 4'd11;  // accumulator complete
  localparam logic [3:0] STEP_DECIDE  = 4'd12;

  logic [1:0]    state, state_next;
  logic [3:0]    step, step_next;
  logic [RW-1:0] rounds, rounds_next;
  logic          out_valid_next;
  mul_op_t       mul_s;
  wb_op_t        wb_s;

  // at most one product issued per step; each product is registered in prod and written back from there by wb_s
  always_comb begin
    mul_s = MUL_NONE;
    wb_s  = WB_NONE;
    case (step)
      4'd0:  begin mul_s = MUL_TT;   wb_s = WB_NONE;    end
      4'd1:  begin mul_s = MUL_SS;   wb_s = WB_T2;      end
      4'd2:  begin mul_s = MUL_T2T;  wb_s = WB_S2;      end
      4'd3:  begin mul_s = MUL_S2S;  wb_s = WB_W3;      end
      4'd4:  begin mul_s = MUL_S2T;  wb_s = WB_W0;      end
      4'd5:  begin mul_s = MUL_ST2;  wb_s = WB_W1;      end
      4'd6:  begin mul_s = MUL_W0P;  wb_s = WB_W2;      end
      4'd7:  begin mul_s = MUL_W1P;  wb_s = WB_ACC_LD;  end
      4'd8:  begin mul_s = MUL_W2P;  wb_s = WB_ACC_ADD; end
      4'd9:  begin mul_s = MUL_W3P;  wb_s = WB_ACC_ADD; end
      4'd10: begin mul_s = MUL_NONE; wb_s = WB_ACC_ADD; end
      4'd11: begin mul_s = MUL_NONE; wb_s = WB_XR;      end
      default: begin mul_s = MUL_NONE; wb_s = WB_NONE;  end
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    state_next     = state;
    step_next      = step;
    rounds_next    = rounds;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          state_next  = ST_XEVAL;
          step_next   = STEP_FIRST;
          rounds_next = '0;
        end
      end
      ST_XEVAL: begin
        cmd.mul_op = mul_s;
        cmd.wb_op  = wb_s;
        cmd.calc_s = (step == STEP_FIRST);
        if (step == STEP_DECIDE) begin
          if (!status.in_tol && !status.t_at_one &&
              (rounds < RW'(MAX_ITERATIONS))) begin
            cmd.step_t  = 1'b1;
            rounds_next = rounds + 1'b1;
            step_next   = STEP_FIRST;
          end else begin
            cmd.set_conv = 1'b1;
            state_next   = ST_YEVAL;
            step_next    = STEP_Y_FIRST;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_YEVAL: begin
        // weights of the final t are reused; only the y products run
        cmd.sel_y  = 1'b1;
        cmd.mul_op = mul_s;
        cmd.wb_op  = (step == STEP_Y_FIRST || step == STEP_RES) ? WB_NONE : wb_s;
        if (step == STEP_RES) begin
          if (!out_valid || out_ready) begin
            cmd.finish     = 1'b1;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_FIRST;
      rounds    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      rounds    <= rounds_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

[src/bezier_curve_y_at_x_solver.sv]
`default_nettype none
// Items: one at a time; a new input is accepted only once the previous item
//   has left the sequencer, after R (0..MAX_ITERATIONS) refinement rounds.
// Each evaluation of x(t) issues ten products through the single shared
//   multiplier in the datapath.
// Reset (rst, synchronous): idle, no result pending, x_tolerance = 7.
// ----------------------------------------------------------------------------
// bezier_curve_y_at_x_solver: cubic Bezier y lookup at a target x
// Bisects t on [0,1] from t = 0.5 until x(t) meets the tolerance, t reaches
// one or the round limit is hit, then returns saturated y(t) and a converged flag.
// ----------------------------------------------------------------------------
module bezier_curve_y_at_x_solver import bcy_pkg::*; #(
  parameter int T_FRAC_BITS    = DEF_T_FRAC_BITS,
  parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration: x_tolerance, written whenever cfg_wr_en is high
  input  wire logic             cfg_wr_en,
  input  wire logic [TOL_W-1:0] cfg_wr_data,
  // input transaction
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  // result transaction
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  // Controller and datapath talk only through cmd and status.
  // Per round: steps 0-5 build the Bernstein weights from t and s = 1 - t,
  // steps 6-10 accumulate weight * control point, step 11 clamps x(t),
  // step 12 tests the tolerance and either moves a bound or exits.
  // The y pass reuses the weights of the final t (steps 6-11 only).
  // The output register lets a new transaction start while a result waits.
  bcy_cmd_t    cmd;
  bcy_status_t status;

  bcy_ctrl #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bcy_datapath #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is pending");

  // one item in flight: after an input transaction the input side closes
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // bounds only move while the tolerance is not met
  a_step_needs_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.step_t |-> !status.in_tol)
    else $error("bisection step taken after convergence");

  // sequencing events are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step_t, cmd.set_conv, cmd.finish}))
    else $error("conflicting controller commands");

endmodule
`default_nettype wire

[test/bezier_curve_y_at_x_solver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_y_at_x_solver_test: self-checking bench for the y-at-x solver
// Runs a directed table and then random curves through several tolerance
// settings and idle/stall patterns. Each result is checked against a local
// bisection predictor, or against a typed-in value where one is obvious.
// ----------------------------------------------------------------------------
module bezier_curve_y_at_x_solver_test import bcy_pkg::*; ();

  // fixed-point setup of the default build
  localparam int     TF    = DEF_T_FRAC_BITS;
  localparam longint T_ONE = longint'(1) << TF;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  // the watchdog allows many times the worst-case latency of one item
  localparam int WATCHDOG_CYCLES  = 4000;
  localparam int END_WAIT_CYCLES  = 240;
  localparam int ITEMS_PER_PHASE  = 150;
  localparam int NUM_PHASES       = 6;
  localparam int PAUSE_AT_ITEM    = 75;

  // idle patterns
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [TOL_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_item_t        out_data;

  // a directed row: the stimulus plus an optional typed-in answer
  typedef struct {
    in_item_t  item;
    bit        literal;
    out_item_t answer;
  } dir_row_t;

  dir_row_t  dir_rows[$];
  out_item_t y_expected[$];     // results still owed by the block, oldest first
  longint    x_tol_model;       // local copy of the tolerance register
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;

  bezier_curve_y_at_x_solver dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One cubic evaluation at t (0..T_ONE). Weights are truncated products,
  // the weighted sum is floored by TF bits and clamped to 32-bit signed.
  function automatic logic signed [DATA_W-1:0] bezier_at(input longint t,
      input longint p0, input longint p1, input longint p2, input longint p3);
    longint s, t2, s2, w0, w1, w2, w3, acc, r;
    s   = T_ONE - t;
    t2  = (t * t) >> TF;
    s2  = (s * s) >> TF;
    w0  = (s2 * s) >> TF;
    w1  = (3 * s2 * t) >> TF;
    w2  = (3 * s * t2) >> TF;
    w3  = (t2 * t) >> TF;
    acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
    r   = acc >>> TF;
    if (r > Y_MAX) r = Y_MAX;
    if (r < Y_MIN) r = Y_MIN;
    return r[DATA_W-1:0];
  endfunction

  function automatic longint x_error(input longint a, input longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  // Bisection on t from 0.5: raise the lower bound while the target is to the
  // right of x(t), else drop the upper bound. Stops on tolerance, t at one,
  // or after the round limit; y is then evaluated at the final t.
  function automatic out_item_t solve_y_at_x(input in_item_t it, input longint tol);
    out_item_t res;
    longint    lo, hi, t, xt, xr;
    int        rounds;
    lo     = 0;
    hi     = T_ONE;
    t      = (lo + hi) >> 1;
    xt     = it.x_target;
    xr     = bezier_at(t, it.start_x, it.handle_a_x, it.handle_b_x, it.end_x);
    rounds = 0;
    while (x_error(xt, xr) > tol && t < T_ONE && rounds < DEF_MAX_ITERATIONS) begin
      if (xt > xr) lo = t;
      else hi = t;
      t  = (lo + hi) >> 1;
      xr = bezier_at(t, it.start_x, it.handle_a_x, it.handle_b_x, it.end_x);
      rounds++;
    end
    res.y_value   = bezier_at(t, it.start_y, it.handle_a_y, it.handle_b_y, it.end_y);
    res.converged = (x_error(xt, xr) <= tol);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic in_item_t make_item(
      input logic signed [DATA_W-1:0] xt,
      input logic signed [DATA_W-1:0] x0, input logic signed [DATA_W-1:0] y0,
      input logic signed [DATA_W-1:0] x1, input logic signed [DATA_W-1:0] y1,
      input logic signed [DATA_W-1:0] x2, input logic signed [DATA_W-1:0] y2,
      input logic signed [DATA_W-1:0] x3, input logic signed [DATA_W-1:0] y3);
    in_item_t it;
    it.x_target   = xt;
    it.start_x    = x0;
    it.start_y    = y0;
    it.handle_a_x = x1;
    it.handle_a_y = y1;
    it.handle_b_x = x2;
    it.handle_b_y = y2;
    it.end_x      = x3;
    it.end_y      = y3;
    return it;
  endfunction

  task automatic add_row(input in_item_t it, input bit literal,
                         input logic signed [DATA_W-1:0] y, input logic conv);
    dir_row_t row;
    row.item             = it;
    row.literal          = literal;
    row.answer.y_value   = y;
    row.answer.converged = conv;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Mostly well-formed curves (monotonic x, target inside the x range) so the
  // bisection actually homes in; the rest are looped curves, corners, noise.
  function automatic in_item_t gen_item();
    in_item_t            it;
    logic [8:0][31:0]    raw;
    int unsigned         kind, span, d1, d2;
    int                  base;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) raw[i] = $urandom;
    if (kind < 10) begin
      for (int i = 0; i < 9; i++) begin
        case ($urandom_range(4))
          0: raw[i] = S32_MAX;
          1: raw[i] = S32_MIN;
          2: raw[i] = '0;
          3: raw[i] = '1;
          default: raw[i] = $urandom;
        endcase
      end
    end
    it = in_item_t'(raw);
    if (kind >= 25) begin
      span = $urandom_range(1, 32'h0100_0000) >> $urandom_range(0, 20);
      if (span == 0) span = 1;
      base = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      d1   = $urandom_range(0, span);
      d2   = $urandom_range(d1, span);
      it.start_x    = base;
      it.handle_a_x = base + int'(d1);
      it.handle_b_x = base + int'(d2);
      it.end_x      = base + int'(span);
      it.x_target   = base + int'($urandom_range(0, span));
      // looped curve: handles thrown well past the ends
      if (kind < 40) begin
        it.handle_a_x = base + int'($urandom_range(0, 4 * span)) - int'(span);
        it.handle_b_x = base + int'($urandom_range(0, 4 * span)) - 2 * int'(span);
      end
      // target a little outside the range now and then
      if ($urandom_range(9) == 0) it.x_target = it.end_x + int'($urandom_range(0, 64));
      // decreasing curve
      if ($urandom_range(1)) begin
        it.start_x    = -it.start_x;
        it.handle_a_x = -it.handle_a_x;
        it.handle_b_x = -it.handle_b_x;
        it.end_x      = -it.end_x;
        it.x_target   = -it.x_target;
      end
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  task automatic set_idle_mode(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 61 : (mode == IDLE_BOTH) ? 11 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 61 : (mode == IDLE_BOTH) ? 11 : 0;
  endtask

  // Only called with the block idle; the model follows at the same edge.
  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    x_tol_model = value;
  endtask

  // One input transaction, with a random gap in front of it. The expectation
  // is queued at the accepting edge, under the tolerance in force then.
  task automatic send_item(input in_item_t it, input bit literal, input out_item_t answer);
    out_item_t owed;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    owed = literal ? answer : solve_y_at_x(it, x_tol_model);
    y_expected.insert(y_expected.size(), owed);
  endtask

  // Drop valid and hold off until every owed result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (y_expected.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (y_expected.size() == 0) begin
        $display("%0t: result with none expected: y_value %h converged %b",
                 $realtime, out_data.y_value, out_data.converged);
        mismatch_count++;
      end else begin
        want = y_expected.pop_front();
        if (out_data.y_value !== want.y_value) begin
          $display("%0t: y_value mismatch: expected %h, actual %h",
                   $realtime, want.y_value, out_data.y_value);
          mismatch_count++;
        end
        if (out_data.converged !== want.converged) begin
          $display("%0t: converged mismatch: expected %b, actual %b",
                   $realtime, want.converged, out_data.converged);
          mismatch_count++;
        end
      end
    end
    // count cycles in which neither channel moves a transaction
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $realtime, y_expected.size());
      $display("bezier_curve_y_at_x_solver_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    out_item_t   none;
    logic [TOL_W-1:0] tol;
    none = '0;
    x_tol_model = XTOL_RESET;

    // Directed table. Typed-in answers:
    //  - flat curves hit their constant exactly at t = 0.5 (the weights sum
    //    to exactly one there), so y is the y constant and converged is set;
    //  - a flat x at zero with an unreachable target walks the bisection to
    //    its round limit without meeting tolerance; y is zero with flat y zero;
    //  - tolerance boundary: an error equal to the reset tolerance passes,
    //    one more does not.
    add_row(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1, '0, 1'b1);
    add_row(make_item(S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MIN,
                      S32_MAX, S32_MIN, S32_MAX, S32_MIN), 1'b1, S32_MIN, 1'b1);
    add_row(make_item(S32_MIN, S32_MIN, S32_MAX, S32_MIN, S32_MAX,
                      S32_MIN, S32_MAX, S32_MIN, S32_MAX), 1'b1, S32_MAX, 1'b1);
    add_row(make_item(S32_MAX, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1, '0, 1'b0);
    add_row(make_item(S32_MIN, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1, '0, 1'b0);
    add_row(make_item(Q_ONE + 7, Q_ONE, 5 * Q_ONE, Q_ONE, 5 * Q_ONE,
                      Q_ONE, 5 * Q_ONE, Q_ONE, 5 * Q_ONE), 1'b1, 5 * Q_ONE, 1'b1);
    add_row(make_item(Q_ONE + 8, Q_ONE, '0, Q_ONE, '0, Q_ONE, '0, Q_ONE, '0),
            1'b1, '0, 1'b0);
    // predicted rows: straight line, both ends, decreasing, looped curve
    add_row(make_item(Q_ONE / 4, '0, '0, 21845, 43691, 43691, 87381, Q_ONE, 2 * Q_ONE),
            1'b0, '0, 1'b0);
    add_row(make_item('0, '0, '0, 21845, 43691, 43691, 87381, Q_ONE, 2 * Q_ONE),
            1'b0, '0, 1'b0);
    add_row(make_item(Q_ONE, '0, '0, 21845, 43691, 43691, 87381, Q_ONE, 2 * Q_ONE),
            1'b0, '0, 1'b0);
    add_row(make_item(19661, Q_ONE, -Q_ONE, 43691, Q_ONE, 21845, -Q_ONE, '0, Q_ONE),
            1'b0, '0, 1'b0);
    add_row(make_item(Q_ONE / 2, '0, '0, 3 * Q_ONE, 4 * Q_ONE, -2 * Q_ONE, -4 * Q_ONE,
                      Q_ONE, '0), 1'b0, '0, 1'b0);
    // field extremes
    add_row(make_item(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                      S32_MAX, S32_MAX, S32_MAX, S32_MAX), 1'b0, '0, 1'b0);
    add_row(make_item(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                      S32_MIN, S32_MIN, S32_MIN, S32_MIN), 1'b0, '0, 1'b0);
    add_row(make_item('0, S32_MIN, S32_MAX, S32_MAX, S32_MIN,
                      S32_MIN, S32_MAX, S32_MAX, S32_MIN), 1'b0, '0, 1'b0);
    add_row(make_item('1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0, 1'b0);
    add_row(make_item(S32_MAX, S32_MIN, S32_MIN, '0, S32_MAX, '0, S32_MIN,
                      S32_MAX, S32_MAX), 1'b0, '0, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs under the reset tolerance, light idling both ways
    set_idle_mode(IDLE_BOTH);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].literal,
                                    dir_rows[i].answer);
    drain_results();

    // random phases: each one sets a tolerance while idle, then an idle mode
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: tol = '0;
        1: tol = '1;
        2: tol = TOL_W'($urandom_range(1, 32));
        3: tol = TOL_W'($urandom_range(0, 16'hFFFF));
        4: tol = 16'd1;
        default: tol = XTOL_RESET;
      endcase
      write_tolerance(tol);
      set_idle_mode(idle_mode_t'(ph % 4));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mid-phase, let the block run dry before going on
        if (n == PAUSE_AT_ITEM) drain_results();
        send_item(gen_item(), 1'b0, none);
      end
      drain_results();
    end

    // every result is in; give the block its worst-case latency to misbehave
    repeat (END_WAIT_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && y_expected.size() == 0) begin
      $display("bezier_curve_y_at_x_solver_test: clean");
    end else begin
      $display("bezier_curve_y_at_x_solver_test: errors");
    end
    $finish;
  end

endmodule
